/* sv/njs_pkg.sv */
// ----------------------------------------------------------------------------
// njs_pkg
// Shared constants, register indexes and types of the nine-point stencil.
// ----------------------------------------------------------------------------
package njs_pkg;

	localparam int DATA_W          = 32;
	localparam int COUNT_W         = 11;
	localparam int VALUE_BITS      = 32;
	localparam int SAT_BITS        = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int OUT_DEPTH       = 16;
	localparam int ADDR_W          = 5;
	localparam int REG_IDX_W       = 3;
	localparam int WIN_N           = 9;
	localparam int OPND_W          = 34;
	localparam int PROD_W          = OPND_W + DATA_W;
	localparam int ACC_W           = PROD_W + 3;
	localparam int FRAC_SHIFT      = 30;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_HORZ   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_VERT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_DIAG   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COEF_SRC_C  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_COEF_SRC_X  = 3'd6;

	localparam logic [COUNT_W-1:0] GRID_RESET = 11'd1024;
	localparam logic [COUNT_W-1:0] MIN_DIM    = 11'd3;

	typedef logic signed [DATA_W-1:0] value_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic [COUNT_W-1:0] grid_w;
		logic [COUNT_W-1:0] grid_h;
		value_t             coef_h;
		value_t             coef_v;
		value_t             coef_g;
		value_t             coef_c;
		value_t             coef_x;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
		logic clear;
	} ctrl_t;

	typedef struct packed {
		value_t old_top;
		value_t old_mid;
		value_t src_top;
		value_t src_mid;
	} line_entry_t;

	typedef struct packed {
		value_t              new_value;
		logic [DATA_W-2:0]   abs_change;
		logic [DATA_W-2:0]   max_change;
		logic                last_of_sweep;
	} result_t;

endpackage

/* sv/njs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// njs_cfg_regs
// APB register file: grid size and the five stencil coefficients.
// ----------------------------------------------------------------------------
module njs_cfg_regs #(
	parameter int MAX_COLUMNS = njs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [njs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output njs_pkg::cfg_t              cfg
);
	import njs_pkg::*;

	localparam int WCAP = (MAX_COLUMNS < 2047) ? MAX_COLUMNS : 2047;
	localparam logic [COUNT_W-1:0] W_CAP = COUNT_W'(WCAP);

	logic [COUNT_W-1:0]   grid_width_q, grid_height_q;
	value_t               coef_h_q, coef_v_q, coef_g_q, coef_c_q, coef_x_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
			coef_h_q      <= '0;
			coef_v_q      <= '0;
			coef_g_q      <= '0;
			coef_c_q      <= '0;
			coef_x_q      <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[COUNT_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[COUNT_W-1:0];
				REG_COEF_HORZ:   coef_h_q      <= pwdata;
				REG_COEF_VERT:   coef_v_q      <= pwdata;
				REG_COEF_DIAG:   coef_g_q      <= pwdata;
				REG_COEF_SRC_C:  coef_c_q      <= pwdata;
				REG_COEF_SRC_X:  coef_x_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			REG_COEF_HORZ:   prdata = coef_h_q;
			REG_COEF_VERT:   prdata = coef_v_q;
			REG_COEF_DIAG:   prdata = coef_g_q;
			REG_COEF_SRC_C:  prdata = coef_c_q;
			REG_COEF_SRC_X:  prdata = coef_x_q;
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		priority if (grid_width_q < MIN_DIM) begin
			cfg.grid_w = MIN_DIM;
		end else if (grid_width_q > W_CAP) begin
			cfg.grid_w = W_CAP;
		end else begin
			cfg.grid_w = grid_width_q;
		end
		cfg.grid_h = (grid_height_q < MIN_DIM) ? MIN_DIM : grid_height_q;
		cfg.coef_h = coef_h_q;
		cfg.coef_v = coef_v_q;
		cfg.coef_g = coef_g_q;
		cfg.coef_c = coef_c_q;
		cfg.coef_x = coef_x_q;
	end

endmodule

/* sv/njs_window.sv */
// ----------------------------------------------------------------------------
// njs_window
// Raster counters, two-row line store memory and the 3x3 windows of
// previous iterate and source values.
// ----------------------------------------------------------------------------
module njs_window #(
	parameter int MAX_COLUMNS = njs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  njs_pkg::value_t             old_value,
	input  njs_pkg::value_t             source_value,
	input  logic                        clear_max,
	input  logic [njs_pkg::COUNT_W-1:0] grid_w,
	input  logic [njs_pkg::COUNT_W-1:0] grid_h,
	output logic                        emit_now,
	output njs_pkg::ctrl_t              ctrl_s2,
	output njs_pkg::value_t             old_win [njs_pkg::WIN_N],
	output njs_pkg::value_t             src_win [njs_pkg::WIN_N]
);
	import njs_pkg::*;

	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam logic [COUNT_W-1:0] TWO = COUNT_W'(2);

	line_entry_t        mem [MAX_COLUMNS];
	line_entry_t        rd_q;
	logic [COUNT_W-1:0] col_q, row_q;
	logic [COUNT_W:0]   col_inc, row_inc;
	logic               col_wrap, row_wrap, last_now, mem_ok;
	logic [AW-1:0]      addr;
	logic [AW-1:0]      addr_s1;
	logic               ok_s1;
	value_t             old_s1, src_s1;
	ctrl_t              ctrl_s1;
	value_t             old_win_q [WIN_N];
	value_t             src_win_q [WIN_N];
	value_t             top_old, mid_old, top_src, mid_src;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign col_wrap = col_inc >= {1'b0, grid_w};
	assign row_wrap = row_inc >= {1'b0, grid_h};
	assign emit_now = (row_q >= TWO) && (row_q < grid_h) && (col_q >= TWO) && (col_q < grid_w);
	assign last_now = (row_inc == {1'b0, grid_h}) && (col_inc == {1'b0, grid_w});
	assign mem_ok   = 32'(col_q) < 32'(MAX_COLUMNS);
	assign addr     = AW'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[COUNT_W-1:0];
			end else begin
				col_q <= col_inc[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= '{valid: in_accept, emit: emit_now, last: last_now, clear: clear_max};
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_s1 <= addr;
			ok_s1   <= mem_ok;
			old_s1  <= old_value;
			src_s1  <= source_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && mem_ok) begin
			rd_q <= mem[addr];
		end
		if (ctrl_s1.valid && ok_s1) begin
			mem[addr_s1] <= '{old_top: rd_q.old_mid, old_mid: old_s1,
				src_top: rd_q.src_mid, src_mid: src_s1};
		end
	end

	assign top_old = ok_s1 ? rd_q.old_top : '0;
	assign mid_old = ok_s1 ? rd_q.old_mid : '0;
	assign top_src = ok_s1 ? rd_q.src_top : '0;
	assign mid_src = ok_s1 ? rd_q.src_mid : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_N; i++) begin
				old_win_q[i] <= '0;
				src_win_q[i] <= '0;
			end
		end else if (ctrl_s1.valid) begin
			for (int k = 0; k < 3; k++) begin
				old_win_q[k*3]   <= old_win_q[k*3+1];
				old_win_q[k*3+1] <= old_win_q[k*3+2];
				src_win_q[k*3]   <= src_win_q[k*3+1];
				src_win_q[k*3+1] <= src_win_q[k*3+2];
			end
			old_win_q[2] <= top_old;
			old_win_q[5] <= mid_old;
			old_win_q[8] <= old_s1;
			src_win_q[2] <= top_src;
			src_win_q[5] <= mid_src;
			src_win_q[8] <= src_s1;
		end
	end

	assign old_win = old_win_q;
	assign src_win = src_win_q;

endmodule

/* sv/njs_kernel.sv */
// ----------------------------------------------------------------------------
// njs_kernel
// Stencil arithmetic: pre-adds, five multiplies, accumulate, round,
// saturate, absolute change and running maximum.
// ----------------------------------------------------------------------------
module njs_kernel (
	input  logic            clk,
	input  logic            arst_n,
	input  njs_pkg::cfg_t   cfg,
	input  njs_pkg::ctrl_t  ctrl_s2,
	input  njs_pkg::value_t old_win [njs_pkg::WIN_N],
	input  njs_pkg::value_t src_win [njs_pkg::WIN_N],
	output logic            push,
	output njs_pkg::result_t push_data
);
	import njs_pkg::*;

	localparam int QW = ACC_W - FRAC_SHIFT;
	localparam acc_t   ROUND_C = acc_t'(1 << (FRAC_SHIFT - 1));
	localparam value_t SAT_MAX = value_t'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam value_t SAT_MIN = ~SAT_MAX;

	ctrl_t             ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6, ctrl_s7, ctrl_s8;
	opnd_t             sum_h_s3, sum_v_s3, sum_g_s3, sum_x_s3, src_c_s3;
	value_t            centre_s3, centre_s4, centre_s5, centre_s6, centre_s7;
	prod_t             prod_h_s4, prod_v_s4, prod_g_s4, prod_c_s4, prod_x_s4;
	acc_t              part_a_s5, part_b_s5, part_x_s5;
	acc_t              total_s6;
	value_t            res_s7, res_s8;
	logic [DATA_W-2:0] abs_s8;
	logic [DATA_W-2:0] max_q, max_base, max_next;
	logic signed [QW-1:0]       quot;
	logic [QW-SAT_BITS:0]       quot_top;
	logic signed [DATA_W:0]     diff;
	logic [DATA_W:0]            mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
			ctrl_s6 <= '0;
			ctrl_s7 <= '0;
			ctrl_s8 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			ctrl_s6 <= ctrl_s5;
			ctrl_s7 <= ctrl_s6;
			ctrl_s8 <= ctrl_s7;
		end
	end

	assign quot     = total_s6[ACC_W-1:FRAC_SHIFT];
	assign quot_top = quot[QW-1:SAT_BITS-1];
	assign diff     = (DATA_W+1)'(res_s7) - (DATA_W+1)'(centre_s7);
	assign mag      = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);

	always_ff @(posedge clk) begin
		sum_h_s3  <= OPND_W'(old_win[3]) + OPND_W'(old_win[5]);
		sum_v_s3  <= OPND_W'(old_win[1]) + OPND_W'(old_win[7]);
		sum_g_s3  <= OPND_W'(old_win[0]) + OPND_W'(old_win[2])
			+ OPND_W'(old_win[6]) + OPND_W'(old_win[8]);
		sum_x_s3  <= OPND_W'(src_win[1]) + OPND_W'(src_win[7])
			+ OPND_W'(src_win[3]) + OPND_W'(src_win[5]);
		src_c_s3  <= OPND_W'(src_win[4]);
		centre_s3 <= old_win[4];

		prod_h_s4 <= sum_h_s3 * cfg.coef_h;
		prod_v_s4 <= sum_v_s3 * cfg.coef_v;
		prod_g_s4 <= sum_g_s3 * cfg.coef_g;
		prod_c_s4 <= src_c_s3 * cfg.coef_c;
		prod_x_s4 <= sum_x_s3 * cfg.coef_x;
		centre_s4 <= centre_s3;

		part_a_s5 <= ACC_W'(prod_h_s4) + ACC_W'(prod_v_s4);
		part_b_s5 <= ACC_W'(prod_g_s4) + ACC_W'(prod_c_s4);
		part_x_s5 <= ACC_W'(prod_x_s4) + ROUND_C;
		centre_s5 <= centre_s4;

		total_s6  <= part_a_s5 + part_b_s5 + part_x_s5;
		centre_s6 <= centre_s5;

		if ((&quot_top) || !(|quot_top)) begin
			res_s7 <= value_t'(quot[DATA_W-1:0]);
		end else begin
			res_s7 <= quot[QW-1] ? SAT_MIN : SAT_MAX;
		end
		centre_s7 <= centre_s6;

		abs_s8 <= (|mag[DATA_W:DATA_W-1]) ? '1 : mag[DATA_W-2:0];
		res_s8 <= res_s7;
	end

	assign max_base = ctrl_s8.clear ? '0 : max_q;
	assign max_next = (ctrl_s8.emit && (abs_s8 > max_base)) ? abs_s8 : max_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (ctrl_s8.valid) begin
			max_q <= max_next;
		end
	end

	assign push      = ctrl_s8.valid & ctrl_s8.emit;
	assign push_data = '{new_value: res_s8, abs_change: abs_s8, max_change: max_next,
		last_of_sweep: ctrl_s8.last};

endmodule

/* sv/njs_out_fifo.sv */
// ----------------------------------------------------------------------------
// njs_out_fifo
// Result queue with credit count; the credit is taken when an emitting word
// enters the block and returned when the result word leaves.
// ----------------------------------------------------------------------------
module njs_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             reserve,
	input  logic             push,
	input  njs_pkg::result_t push_data,
	input  logic             out_stall,
	output logic             out_valid,
	output njs_pkg::result_t head,
	output logic             credit_full
);
	import njs_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);
	localparam logic [PW:0] DEPTH_C = (PW+1)'(OUT_DEPTH);

	result_t       mem_q [OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q, credit_q;
	logic          pop;

	assign out_valid   = count_q != '0;
	assign pop         = out_valid & ~out_stall;
	assign credit_full = credit_q == DEPTH_C;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q  <= count_q + (PW+1)'(push) - (PW+1)'(pop);
			credit_q <= credit_q + (PW+1)'(reserve) - (PW+1)'(pop);
		end
	end

endmodule

/* sv/nine_point_jacobi_stencil.sv */
// ----------------------------------------------------------------------------
// nine_point_jacobi_stencil
// One Jacobi sweep of a nine-point compact stencil over a raster stream of
// grid points, with absolute and running maximum change per interior point.
//
//   channel  direction  handshake          word
//   in       sink       in_valid/in_stall  old_value, source_value, clear_max
//   out      source     out_valid/out_stall new_value, abs_change, max_change,
//                                           last_of_sweep
//   cfg      APB        psel/penable       7 registers at 4*index
//
// One grid point a cycle while in_stall is low; a result is offered once
// it has passed window stages s1, s2, kernel stages s3 to s8 and the queue.
// The line store is one memory with read-modify-write; the write lands in the cycle after the read.
// A 16-word result queue bounds the words in flight: in_stall rises when
// sixteen results are owed and out_stall holds them.
// Reset clears counters, windows, running maximum and queue; the line
// store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module nine_point_jacobi_stencil #(
	parameter int MAX_COLUMNS = njs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  njs_pkg::value_t                 old_value,
	input  njs_pkg::value_t                 source_value,
	input  logic                            clear_max,
	output logic                            out_valid,
	input  logic                            out_stall,
	output njs_pkg::value_t                 new_value,
	output logic [njs_pkg::DATA_W-2:0]      abs_change,
	output logic [njs_pkg::DATA_W-2:0]      max_change,
	output logic                            last_of_sweep,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [njs_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import njs_pkg::*;

	cfg_t    cfg;
	ctrl_t   ctrl_s2;
	value_t  old_win [WIN_N];
	value_t  src_win [WIN_N];
	logic    in_accept, emit_now, push, credit_full;
	result_t push_data, head;

	assign in_stall  = credit_full;
	assign in_accept = in_valid & ~in_stall;

	njs_cfg_regs #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	njs_window #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.old_value    (old_value),
		.source_value (source_value),
		.clear_max    (clear_max),
		.grid_w       (cfg.grid_w),
		.grid_h       (cfg.grid_h),
		.emit_now     (emit_now),
		.ctrl_s2      (ctrl_s2),
		.old_win      (old_win),
		.src_win      (src_win)
	);

	njs_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ctrl_s2   (ctrl_s2),
		.old_win   (old_win),
		.src_win   (src_win),
		.push      (push),
		.push_data (push_data)
	);

	njs_out_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.reserve     (in_accept & emit_now),
		.push        (push),
		.push_data   (push_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.head        (head),
		.credit_full (credit_full)
	);

	assign new_value     = head.new_value;
	assign abs_change    = head.abs_change;
	assign max_change    = head.max_change;
	assign last_of_sweep = head.last_of_sweep;

endmodule

/* sv/njs_checker.sv */
// ----------------------------------------------------------------------------
// njs_checker
// Port-level checks on the stencil block, bound to the top level.
// ----------------------------------------------------------------------------
module njs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] new_value,
	input logic [30:0] abs_change,
	input logic [30:0] max_change,
	input logic        last_of_sweep
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(new_value) && $stable(abs_change)
			&& $stable(max_change) && $stable(last_of_sweep))
		else $error("result word changed while stalled");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> max_change >= abs_change)
		else $error("running maximum below the change it includes");

	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ##10 out_valid)
		else $error("input held off with no result word delivered");

endmodule

bind nine_point_jacobi_stencil njs_checker u_njs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.new_value     (new_value),
	.abs_change    (abs_change),
	.max_change    (max_change),
	.last_of_sweep (last_of_sweep)
);
